// ===== src/isc_pkg.sv =====
package isc_pkg;

    localparam int ChW    = 8;
    localparam int ValueW = 64;
    localparam int ModeW  = 3;

    localparam logic [ModeW-1:0] MODE_IDLE  = 3'd0;
    localparam logic [ModeW-1:0] MODE_ZERO  = 3'd1;
    localparam logic [ModeW-1:0] MODE_BIN   = 3'd2;
    localparam logic [ModeW-1:0] MODE_OCT   = 3'd3;
    localparam logic [ModeW-1:0] MODE_HEX   = 3'd4;
    localparam logic [ModeW-1:0] MODE_DEC   = 3'd5;
    localparam logic [ModeW-1:0] MODE_LZDEC = 3'd6;

    localparam logic [1:0] STATUS_INT  = 2'd0;
    localparam logic [1:0] STATUS_REAL = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    typedef struct packed {
        logic       dig;
        logic       zero;
        logic       one;
        logic       octd;
        logic [3:0] dv;
        logic       idst;
        logic       sep;
        logic       real_start;
        logic       hexd;
        logic [3:0] hv;
        logic       is_b;
        logic       is_o;
        logic       is_x;
    } cls_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        base;
        logic [ValueW-1:0] value;
        logic              overflowed;
        logic              dirty;
        logic              has_suffix;
    } res_t;

endpackage

// ===== src/isc_classify.sv =====
module isc_classify
    import isc_pkg::*;
(
    input  logic [ChW-1:0] ch,
    output cls_t           cls
);

    logic lower;
    logic upper;
    logic [ChW-1:0] d_off;
    logic [ChW-1:0] l_off;
    logic [ChW-1:0] u_off;

    always_comb
    begin
        lower = (ch >= 8'h61) && (ch <= 8'h7a);
        upper = (ch >= 8'h41) && (ch <= 8'h5a);
        d_off = ch - 8'h30;
        l_off = ch - 8'h57;
        u_off = ch - 8'h37;

        cls.dig        = (ch >= 8'h30) && (ch <= 8'h39);
        cls.zero       = (ch == 8'h30);
        cls.one        = (ch == 8'h31);
        cls.octd       = (ch >= 8'h30) && (ch <= 8'h37);
        cls.dv         = cls.dig ? d_off[3:0] : 4'd0;
        cls.idst       = lower || upper || (ch == 8'h5f);
        cls.sep        = (ch == 8'h27);
        cls.real_start = (ch == 8'h2e) || (ch == 8'h65) || (ch == 8'h45)
                         || (ch == 8'h70) || (ch == 8'h50);
        cls.hexd       = cls.dig || ((ch >= 8'h61) && (ch <= 8'h66))
                         || ((ch >= 8'h41) && (ch <= 8'h46));
        cls.hv         = cls.dig ? d_off[3:0] : (lower ? l_off[3:0] : u_off[3:0]);
        cls.is_b       = (ch == 8'h62) || (ch == 8'h42);
        cls.is_o       = (ch == 8'h6f) || (ch == 8'h4f);
        cls.is_x       = (ch == 8'h78) || (ch == 8'h58);
    end

endmodule

// ===== src/isc_core.sv =====
module isc_core
    import isc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  cls_t cls,
    output logic emit,
    output res_t res
);

    logic [ModeW-1:0]  mode_reg, mode_next;
    logic [ValueW-1:0] acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic              err_reg, err_next;
    logic              sep_reg, sep_next;

    logic [ValueW+3:0] dec_sum;
    logic              err_emit;
    logic [1:0]        r_status;
    logic [1:0]        r_base;
    logic              r_suffix;

    always_comb
    begin
        dec_sum = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                  + {{(ValueW){1'b0}}, cls.dv};

        mode_next = mode_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        err_next  = err_reg;
        sep_next  = sep_reg;
        emit      = 1'b0;
        err_emit  = err_reg;
        r_status  = STATUS_INT;
        r_base    = BASE_DEC;
        r_suffix  = 1'b0;

        case (mode_reg)
            MODE_ZERO:
            begin
                if (cls.is_b)
                begin
                    mode_next = MODE_BIN;
                    sep_next  = 1'b1;
                end
                else if (cls.is_o)
                begin
                    mode_next = MODE_OCT;
                    sep_next  = 1'b1;
                end
                else if (cls.is_x)
                begin
                    mode_next = MODE_HEX;
                    sep_next  = 1'b1;
                end
                else if (cls.dig)
                begin
                    mode_next = MODE_LZDEC;
                    err_next  = 1'b1;
                end
                else if (cls.real_start)
                begin
                    emit     = 1'b1;
                    r_status = STATUS_REAL;
                end
                else if (cls.sep)
                begin
                    emit     = 1'b1;
                    err_emit = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    r_suffix = cls.idst;
                end
            end
            MODE_BIN:
            begin
                if (cls.zero || cls.one)
                begin
                    ovf_next = ovf_reg | acc_reg[ValueW-1];
                    acc_next = {acc_reg[ValueW-2:0], cls.one};
                    sep_next = 1'b0;
                end
                else if (cls.sep)
                begin
                    err_next = err_reg | sep_reg;
                    sep_next = 1'b1;
                end
                else if (cls.dig)
                begin
                    err_next = 1'b1;
                    sep_next = 1'b0;
                end
                else
                begin
                    emit     = 1'b1;
                    r_base   = BASE_BIN;
                    r_suffix = cls.idst;
                end
            end
            MODE_OCT:
            begin
                if (cls.octd)
                begin
                    ovf_next = ovf_reg | (|acc_reg[ValueW-1:ValueW-3]);
                    acc_next = {acc_reg[ValueW-4:0], cls.dv[2:0]};
                    sep_next = 1'b0;
                end
                else if (cls.sep)
                begin
                    err_next = err_reg | sep_reg;
                    sep_next = 1'b1;
                end
                else if (cls.dig)
                begin
                    err_next = 1'b1;
                    sep_next = 1'b0;
                end
                else
                begin
                    emit     = 1'b1;
                    r_base   = BASE_OCT;
                    r_suffix = cls.idst;
                end
            end
            MODE_HEX:
            begin
                if (cls.hexd)
                begin
                    ovf_next = ovf_reg | (|acc_reg[ValueW-1:ValueW-4]);
                    acc_next = {acc_reg[ValueW-5:0], cls.hv};
                    sep_next = 1'b0;
                end
                else if (cls.sep)
                begin
                    err_next = err_reg | sep_reg;
                    sep_next = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    r_base   = BASE_HEX;
                    err_emit = err_reg | cls.idst;
                end
            end
            MODE_DEC:
            begin
                if (cls.dig)
                begin
                    ovf_next = ovf_reg | (|dec_sum[ValueW+3:ValueW]);
                    acc_next = dec_sum[ValueW-1:0];
                    sep_next = 1'b0;
                end
                else if (cls.sep)
                begin
                    err_next = err_reg | sep_reg;
                    sep_next = 1'b1;
                end
                else if (cls.real_start)
                begin
                    emit     = 1'b1;
                    r_status = STATUS_REAL;
                end
                else
                begin
                    emit     = 1'b1;
                    r_suffix = cls.idst;
                end
            end
            MODE_LZDEC:
            begin
                if (!(cls.dig || cls.sep))
                begin
                    emit     = 1'b1;
                    r_suffix = cls.idst;
                end
            end
            default:
            begin
                if (cls.zero)
                begin
                    mode_next = MODE_ZERO;
                end
                else if (cls.dig)
                begin
                    mode_next = MODE_DEC;
                    acc_next  = {{(ValueW-4){1'b0}}, cls.dv};
                    sep_next  = 1'b0;
                end
                else
                begin
                    emit     = 1'b1;
                    r_status = STATUS_NONE;
                end
            end
        endcase

        // an emitted result returns the scanner to its cleared state
        if (emit)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            ovf_next  = 1'b0;
            err_next  = 1'b0;
            sep_next  = 1'b1;
        end

        if (r_status == STATUS_INT)
        begin
            res.status     = r_status;
            res.base       = r_base;
            res.value      = (ovf_reg || err_emit) ? {ValueW{1'b1}} : acc_reg;
            res.overflowed = ovf_reg;
            res.dirty      = err_emit;
            res.has_suffix = r_suffix;
        end
        else
        begin
            res.status     = r_status;
            res.base       = BASE_DEC;
            res.value      = '0;
            res.overflowed = 1'b0;
            res.dirty      = 1'b0;
            res.has_suffix = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            err_reg  <= 1'b0;
            sep_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            err_reg  <= err_next;
            sep_reg  <= sep_next;
        end
    end

endmodule

// ===== src/integer_literal_scanner.sv =====
// channel | transaction        | handshake
// input   | ch                 | in_valid / in_stall
// output  | status, base,      | out_valid / out_stall
//         | value, overflowed, |
//         | dirty, has_suffix  |
// one character per cycle sustained while in_stall is low; a result is
// formed by the input register, then the scan step into result register
// the scan step is one 68-bit shift-add and compare for decimal digits
// rst_n clears the scanner state and both valid registers at once
// a character waits in the input register only while it would end a literal
// and the result register is still held by out_stall
module integer_literal_scanner
    import isc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ChW-1:0]    ch,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [1:0]        base,
    output logic [ValueW-1:0] value,
    output logic              overflowed,
    output logic              dirty,
    output logic              has_suffix
);

    logic           in_valid_reg, in_valid_next;
    logic [ChW-1:0] ch_reg;
    logic           out_valid_reg, out_valid_next;
    res_t           res_reg;

    cls_t cls;
    res_t res;
    logic emit;
    logic out_free;
    logic step;
    logic take_in;

    isc_classify u_classify
    (
        .ch  (ch_reg),
        .cls (cls)
    );

    isc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cls   (cls),
        .emit  (emit),
        .res   (res)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        step           = in_valid_reg && (!emit || out_free);
        in_stall       = in_valid_reg && !step;
        take_in        = in_valid && !in_stall;
        in_valid_next  = take_in || (in_valid_reg && !step);
        out_valid_next = (step && emit) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            ch_reg <= ch;
        end
        if (step && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = res_reg.status;
    assign base       = res_reg.base;
    assign value      = res_reg.value;
    assign overflowed = res_reg.overflowed;
    assign dirty      = res_reg.dirty;
    assign has_suffix = res_reg.has_suffix;

endmodule
